>>> hw/rtl/bulk_string_array_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bulk string array parser
// Clocked assertion shorthands. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef BULK_STRING_ARRAY_PARSER_ASSERT_SVH
`define BULK_STRING_ARRAY_PARSER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BSAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BSAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bsap_pkg.sv
// ----------------------------------------------------------------------------
// bsap_pkg
// Types and constants shared by the bulk string array parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bsap_pkg;

  localparam int LEN_W      = 30;
  localparam int MAX_CNT_W  = 16;
  localparam int CFG_DATA_W = 30;
  localparam int NUM_W      = 34;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic CFG_MAX_COUNT  = 1'b0;
  localparam logic CFG_MAX_LENGTH = 1'b1;

  localparam logic [MAX_CNT_W-1:0] MAX_COUNT_RESET  = 16'd1024;
  localparam logic [LEN_W-1:0]     MAX_LENGTH_RESET = 30'd536870912;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_COUNT    = 4'd1,
    PH_COUNT_LF = 4'd2,
    PH_DOLLAR   = 4'd3,
    PH_LEN      = 4'd4,
    PH_LEN_LF   = 4'd5,
    PH_VALUE    = 4'd6,
    PH_VALUE_LF = 4'd7,
    PH_ERROR    = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_CONT  = 2'd0,
    ST_ERR   = 2'd1,
    ST_PARAM = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    NUM_MORE = 2'd0,
    NUM_BAD  = 2'd1,
    NUM_END  = 2'd2
  } num_verdict_t;

  typedef struct packed {
    num_verdict_t     verdict;
    logic [LEN_W-1:0] accum;
  } digit_res_t;

  typedef struct packed {
    status_t          status;
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic [15:0]      param_index;
    logic [31:0]      param_offset;
    logic [LEN_W-1:0] param_length;
    logic [15:0]      param_count;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/bsap_req_if.sv
// ----------------------------------------------------------------------------
// bsap_req_if
// Request byte channel: one action and one byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsap_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_value;

  modport source (output valid, action, byte_value, input ready);
  modport sink (input valid, action, byte_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bsap_rsp_if.sv
// ----------------------------------------------------------------------------
// bsap_rsp_if
// Parse result channel: one status item per request byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsap_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] param_index;
  logic [31:0] param_offset;
  logic [29:0] param_length;
  logic [15:0] param_count;

  modport source (output valid, status, payload_valid, payload_byte, param_index,
                  param_offset, param_length, param_count, input ready);
  modport sink (input valid, status, payload_valid, payload_byte, param_index,
                param_offset, param_length, param_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bulk_string_array_parser.sv
// ----------------------------------------------------------------------------
// bulk_string_array_parser
// Byte-at-a-time parser for '*' count CR LF ( '$' length CR LF value CR LF )*.
// ----------------------------------------------------------------------------
// Usage: request bytes enter on req, one item per byte, with action set to
// restart the parser instead of parsing. Every accepted item gives exactly
// one result item on rsp: a status (continue, error, parameter done on the CR
// after a value, request done on the final LF), the value byte with
// payload_valid when the byte belongs to a parameter value, and the current
// parameter index, value offset, declared length and declared count.
// The limits max_param_count and max_param_length must be written through
// cfg_we, cfg_index and cfg_data while the block is idle (not enforced).
// Timing: an accepted item sits in the input register, the parse logic
// then updates the state and loads the result register, and the result is
// taken from there. One item per cycle is taken in steady state while
// rsp.ready stays high; the per-byte state update is a single digit
// multiply-add and compare, which sets the clock rate.
// Reset: rst (synchronous) empties both registers, puts the parser in its
// start state and loads the default limits.
// Stalls: while rsp.ready is low the result waits in the result register and
// the input register still takes one more item; req.ready then drops.
// An error is held, every byte giving error status, until a restart item.
// ----------------------------------------------------------------------------
`default_nettype none

module bulk_string_array_parser
  import bsap_pkg::*;
#(
  parameter int COUNT_WIDTH    = 16,
  parameter int POSITION_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bsap_req_if.sink                   req,
  bsap_rsp_if.source                 rsp,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  `include "bulk_string_array_parser_assert.svh"

  // Largest count the count register can hold, clipped to the limit width.
  localparam logic [MAX_CNT_W:0] CountMaskSat = (COUNT_WIDTH >= MAX_CNT_W)
      ? {1'b0, {MAX_CNT_W{1'b1}}}
      : (MAX_CNT_W + 1)'(((MAX_CNT_W + 1)'(1) << COUNT_WIDTH) - (MAX_CNT_W + 1)'(1));

  // Configuration registers.
  logic [MAX_CNT_W-1:0] max_param_count;
  logic [LEN_W-1:0]     max_param_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_param_count  <= MAX_COUNT_RESET;
      max_param_length <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_COUNT:  max_param_count  <= cfg_data[MAX_CNT_W-1:0];
        CFG_MAX_LENGTH: max_param_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. It takes an item whenever it is empty or is being
  // drained into the result register in the same cycle.
  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;
  logic       res_valid;
  res_t       res_q;
  logic       advance;

  assign advance   = in_valid && (!res_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_action <= req.action;
      in_byte   <= req.byte_value;
    end
  end

  // Parser state.
  phase_t                    phase, phase_next;
  logic [LEN_W-1:0]          accum, accum_next;
  logic                      seen, seen_next;
  logic [COUNT_WIDTH-1:0]    total_params, total_params_next;
  logic [COUNT_WIDTH-1:0]    params_done, params_done_next;
  logic [LEN_W-1:0]          expected_length, expected_length_next;
  logic [LEN_W-1:0]          bytes_in_param, bytes_in_param_next;
  logic [POSITION_WIDTH-1:0] position, position_next;
  logic [POSITION_WIDTH-1:0] value_offset, value_offset_next;
  res_t                      res_next;

  // The digit unit is shared by the count and the length fields; only the
  // limit it checks against changes with the phase.
  logic [MAX_CNT_W-1:0] count_limit;
  logic [LEN_W-1:0]     digit_limit;
  digit_res_t           digit;

  assign count_limit = ({1'b0, max_param_count} < CountMaskSat)
      ? max_param_count : CountMaskSat[MAX_CNT_W-1:0];
  assign digit_limit = (phase == PH_LEN) ? max_param_length : LEN_W'(count_limit);

  bsap_digit u_digit (
    .byte_value  (in_byte),
    .accum       (accum),
    .digits_seen (seen),
    .limit       (digit_limit),
    .res         (digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      accum           <= '0;
      seen            <= 1'b0;
      total_params    <= '0;
      params_done     <= '0;
      expected_length <= '0;
      bytes_in_param  <= '0;
      position        <= '0;
      value_offset    <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      accum           <= accum_next;
      seen            <= seen_next;
      total_params    <= total_params_next;
      params_done     <= params_done_next;
      expected_length <= expected_length_next;
      bytes_in_param  <= bytes_in_param_next;
      position        <= position_next;
      value_offset    <= value_offset_next;
    end
  end

  logic finished;

  always_comb begin
    phase_next           = phase;
    accum_next           = accum;
    seen_next            = seen;
    total_params_next    = total_params;
    params_done_next     = params_done;
    expected_length_next = expected_length;
    bytes_in_param_next  = bytes_in_param;
    position_next        = position;
    value_offset_next    = value_offset;
    finished             = 1'b0;
    res_next             = '0;
    res_next.status      = ST_CONT;

    if (in_action) begin
      // Restart: everything back to the start state, an all-zero result.
      phase_next           = PH_START;
      accum_next           = '0;
      seen_next            = 1'b0;
      total_params_next    = '0;
      params_done_next     = '0;
      expected_length_next = '0;
      bytes_in_param_next  = '0;
      position_next        = '0;
      value_offset_next    = '0;
    end else begin
      unique case (phase)
        PH_START: begin
          if (in_byte == CH_STAR) phase_next = PH_COUNT;
          else res_next.status = ST_ERR;
        end
        PH_COUNT: begin
          case (digit.verdict)
            NUM_MORE: begin
              accum_next = digit.accum;
              seen_next  = 1'b1;
            end
            NUM_END: begin
              total_params_next = COUNT_WIDTH'(accum);
              accum_next        = '0;
              seen_next         = 1'b0;
              phase_next        = PH_COUNT_LF;
            end
            default: res_next.status = ST_ERR;
          endcase
        end
        PH_COUNT_LF: begin
          if (in_byte != CH_LF) begin
            res_next.status = ST_ERR;
          end else if (total_params == '0) begin
            res_next.status = ST_DONE;
            finished        = 1'b1;
          end else begin
            phase_next = PH_DOLLAR;
          end
        end
        PH_DOLLAR: begin
          if (in_byte == CH_DOLLAR) phase_next = PH_LEN;
          else res_next.status = ST_ERR;
        end
        PH_LEN: begin
          case (digit.verdict)
            NUM_MORE: begin
              accum_next = digit.accum;
              seen_next  = 1'b1;
            end
            NUM_END: begin
              expected_length_next = accum;
              bytes_in_param_next  = '0;
              accum_next           = '0;
              seen_next            = 1'b0;
              phase_next           = PH_LEN_LF;
            end
            default: res_next.status = ST_ERR;
          endcase
        end
        PH_LEN_LF: begin
          if (in_byte != CH_LF) begin
            res_next.status = ST_ERR;
          end else begin
            value_offset_next = position + POSITION_WIDTH'(1);
            phase_next        = PH_VALUE;
          end
        end
        PH_VALUE: begin
          // Once the declared number of bytes has passed, only CR may follow.
          if (bytes_in_param >= expected_length) begin
            if (in_byte == CH_CR) begin
              res_next.status = ST_PARAM;
              phase_next      = PH_VALUE_LF;
            end else begin
              res_next.status = ST_ERR;
            end
          end else begin
            bytes_in_param_next    = bytes_in_param + LEN_W'(1);
            res_next.payload_valid = 1'b1;
            res_next.payload_byte  = in_byte;
          end
        end
        PH_VALUE_LF: begin
          if (in_byte != CH_LF) begin
            res_next.status = ST_ERR;
          end else begin
            params_done_next = params_done + COUNT_WIDTH'(1);
            if (params_done_next == total_params) begin
              res_next.status = ST_DONE;
              finished        = 1'b1;
            end else begin
              phase_next = PH_DOLLAR;
            end
          end
        end
        default: res_next.status = ST_ERR;
      endcase

      if (res_next.status == ST_ERR) begin
        phase_next = PH_ERROR;
      end else begin
        position_next = position + POSITION_WIDTH'(1);
      end

      // The result shows the state after this byte, before any clearing.
      res_next.param_index  = 16'(params_done_next);
      res_next.param_offset = 32'(value_offset_next);
      res_next.param_length = expected_length_next;
      res_next.param_count  = 16'(total_params_next);

      if (finished) begin
        phase_next           = PH_START;
        accum_next           = '0;
        seen_next            = 1'b0;
        total_params_next    = '0;
        params_done_next     = '0;
        expected_length_next = '0;
        bytes_in_param_next  = '0;
        position_next        = '0;
        value_offset_next    = '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign rsp.valid         = res_valid;
  assign rsp.status        = res_q.status;
  assign rsp.payload_valid = res_q.payload_valid;
  assign rsp.payload_byte  = res_q.payload_byte;
  assign rsp.param_index   = res_q.param_index;
  assign rsp.param_offset  = res_q.param_offset;
  assign rsp.param_length  = res_q.param_length;
  assign rsp.param_count   = res_q.param_count;

  // A held error stays held and keeps reporting error.
  `BSAP_ASSERT_NEXT(a_error_held,
      advance && !in_action && phase == PH_ERROR,
      res_q.status == ST_ERR && phase == PH_ERROR,
      "held error was left without a restart")
  // Only value bytes of the value phase carry payload.
  `BSAP_ASSERT_NEXT(a_payload_phase,
      advance && (in_action || phase != PH_VALUE),
      !res_q.payload_valid,
      "payload flagged outside a parameter value")
  // A restart returns to the start state with the position cleared.
  `BSAP_ASSERT_NEXT(a_restart_clears,
      advance && in_action,
      phase == PH_START && position == '0 && res_q.status == ST_CONT,
      "restart did not clear the parser")
  // An error status and the error phase always go together.
  `BSAP_ASSERT_NEXT(a_error_phase,
      advance && !in_action,
      (res_q.status == ST_ERR) == (phase == PH_ERROR),
      "error status and error phase disagree")

endmodule

`default_nettype wire

>>> hw/rtl/bsap_digit.sv
// ----------------------------------------------------------------------------
// bsap_digit
// Decimal digit step: folds one byte into the number accumulator and checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsap_digit
  import bsap_pkg::*;
(
  input  wire logic [7:0]       byte_value,
  input  wire logic [LEN_W-1:0] accum,
  input  wire logic             digits_seen,
  input  wire logic [LEN_W-1:0] limit,
  output digit_res_t            res
);

  logic             is_digit;
  logic [3:0]       digit;
  logic [NUM_W-1:0] candidate;

  assign is_digit  = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
  assign digit     = 4'(byte_value - CH_ZERO);
  // Times ten as two shifted copies plus the new digit.
  assign candidate = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + NUM_W'(digit);

  always_comb begin
    res.accum   = accum;
    res.verdict = NUM_MORE;
    if (byte_value == CH_CR) begin
      res.verdict = digits_seen ? NUM_END : NUM_BAD;
    end else if (!is_digit) begin
      res.verdict = NUM_BAD;
    end else if (candidate > NUM_W'(limit)) begin
      res.verdict = NUM_BAD;
    end else begin
      res.accum = candidate[LEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> verif/bsap_result_checker.sv
// ----------------------------------------------------------------------------
// bsap_result_checker
// Watches the request and result channels of the bulk string array parser,
// predicts one result item per accepted request item and compares them.
// ----------------------------------------------------------------------------
`default_nettype none

module bsap_result_checker
  import bsap_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  bsap_req_if                        req,
  bsap_rsp_if                        rsp,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Limits as last written.
  logic [15:0]      lim_count;
  logic [LEN_W-1:0] lim_length;

  // Parser state, kept in step with the block.
  phase_t           ph;
  logic [63:0]      acc;
  logic             acc_has_digit;
  logic [15:0]      n_declared;
  logic [15:0]      n_finished;
  logic [LEN_W-1:0] len_declared;
  logic [LEN_W-1:0] len_taken;
  logic [31:0]      pos;
  logic [31:0]      first_value_pos;

  res_t due_results[$];
  int   errs = 0;

  function automatic void clear_parser();
    ph              = PH_START;
    acc             = '0;
    acc_has_digit   = 1'b0;
    n_declared      = '0;
    n_finished      = '0;
    len_declared    = '0;
    len_taken       = '0;
    pos             = '0;
    first_value_pos = '0;
  endfunction

  // Folds one character into the decimal number being read.
  function automatic num_verdict_t take_digit(input logic [7:0] b, input logic [63:0] limit);
    logic [63:0] grown;
    if (b == CH_CR) return acc_has_digit ? NUM_END : NUM_BAD;
    if (b < CH_ZERO || b > CH_NINE) return NUM_BAD;
    grown = acc * 64'd10 + 64'(b - CH_ZERO);
    if (grown > limit) return NUM_BAD;
    acc           = grown;
    acc_has_digit = 1'b1;
    return NUM_MORE;
  endfunction

  function automatic res_t parse_byte(input logic act, input logic [7:0] b);
    res_t         r;
    status_t      st;
    logic         pv;
    logic         finished;
    num_verdict_t v;
    r        = '0;
    st       = ST_CONT;
    pv       = 1'b0;
    finished = 1'b0;
    if (act) begin
      clear_parser();
      return r;
    end
    case (ph)
      PH_START: begin
        if (b == CH_STAR) ph = PH_COUNT;
        else st = ST_ERR;
      end
      PH_COUNT: begin
        v = take_digit(b, {48'd0, lim_count});
        if (v == NUM_BAD) begin
          st = ST_ERR;
        end else if (v == NUM_END) begin
          n_declared    = acc[15:0];
          acc           = '0;
          acc_has_digit = 1'b0;
          ph            = PH_COUNT_LF;
        end
      end
      PH_COUNT_LF: begin
        if (b != CH_LF) begin
          st = ST_ERR;
        end else if (n_declared == 16'd0) begin
          st       = ST_DONE;
          finished = 1'b1;
        end else begin
          ph = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (b == CH_DOLLAR) ph = PH_LEN;
        else st = ST_ERR;
      end
      PH_LEN: begin
        v = take_digit(b, {34'd0, lim_length});
        if (v == NUM_BAD) begin
          st = ST_ERR;
        end else if (v == NUM_END) begin
          len_declared  = acc[LEN_W-1:0];
          acc           = '0;
          acc_has_digit = 1'b0;
          len_taken     = '0;
          ph            = PH_LEN_LF;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          st = ST_ERR;
        end else begin
          first_value_pos = pos + 32'd1;
          ph              = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (len_taken >= len_declared) begin
          if (b == CH_CR) begin
            st = ST_PARAM;
            ph = PH_VALUE_LF;
          end else begin
            st = ST_ERR;
          end
        end else begin
          len_taken = len_taken + LEN_W'(1);
          pv        = 1'b1;
        end
      end
      PH_VALUE_LF: begin
        if (b != CH_LF) begin
          st = ST_ERR;
        end else begin
          n_finished = n_finished + 16'd1;
          if (n_finished == n_declared) begin
            st       = ST_DONE;
            finished = 1'b1;
          end else begin
            ph = PH_DOLLAR;
          end
        end
      end
      default: st = ST_ERR;
    endcase

    if (st == ST_ERR) ph = PH_ERROR;
    else pos = pos + 32'd1;

    r.status        = st;
    r.payload_valid = pv;
    r.payload_byte  = pv ? b : 8'h00;
    r.param_index   = n_finished;
    r.param_offset  = first_value_pos;
    r.param_length  = len_declared;
    r.param_count   = n_declared;
    if (finished) clear_parser();
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst) begin
      clear_parser();
      lim_count  = MAX_COUNT_RESET;
      lim_length = MAX_LENGTH_RESET;
      due_results.delete();
    end else begin
      // Retire the result first: its expectation was queued at an earlier edge.
      if (rsp.valid && rsp.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result item: expected none, got status %0d", $time,
                   rsp.status);
          errs++;
        end else begin
          want = due_results.pop_front();
          compare_field("status", 32'(want.status), 32'(rsp.status));
          compare_field("payload_valid", 32'(want.payload_valid), 32'(rsp.payload_valid));
          compare_field("payload_byte", 32'(want.payload_byte), 32'(rsp.payload_byte));
          compare_field("param_index", 32'(want.param_index), 32'(rsp.param_index));
          compare_field("param_offset", want.param_offset, rsp.param_offset);
          compare_field("param_length", 32'(want.param_length), 32'(rsp.param_length));
          compare_field("param_count", 32'(want.param_count), 32'(rsp.param_count));
        end
      end
      if (req.valid && req.ready) begin
        due_results.insert(due_results.size(), parse_byte(req.action, req.byte_value));
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_COUNT) lim_count = cfg_data[15:0];
        else lim_length = cfg_data[LEN_W-1:0];
      end
    end
    fail_count <= errs;
    open_count <= due_results.size();
  end

endmodule

`default_nettype wire

>>> verif/tb_bulk_string_array_parser.sv
// ----------------------------------------------------------------------------
// tb_bulk_string_array_parser
// Drives request bytes and restarts into the parser under several limit
// settings, with random gaps and result stalls; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bulk_string_array_parser
  import bsap_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is a few thousand items at most; this is many times the slowest
  // correct run with every gap and stall at its longest.
  localparam int CYCLE_LIMIT    = 400000;
  // Result stall long enough to fill both registers of the block.
  localparam int LONG_HOLD      = 60;
  // Settling wait before the verdict, for any result still on its way.
  localparam int SETTLE_CYCLES  = 10;
  localparam int ITEMS_PER_STEP = 130;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bsap_req_if req_bus ();
  bsap_rsp_if rsp_bus ();

  int fail_count;
  int open_count;

  // idle_on and holds_asked link the stimulus to the result-ready process.
  bit idle_on;
  int holds_asked;
  int holds_done;

  // Limits the generator currently shapes requests around.
  longint unsigned count_limit;
  longint unsigned length_limit;
  int              items_sent;

  bulk_string_array_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .rsp       (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bsap_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side. A long hold requested by the stimulus takes priority; it is
  // timed here so that the sender keeps offering items meanwhile. Otherwise
  // ready drops in short random bursts while idling is enabled.
  initial begin : result_ready
    holds_done = 0;
    forever begin
      if (holds_done < holds_asked) begin
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one item and returns at the edge that accepts it. Valid stays high
  // afterwards, so back-to-back items need no extra assignment.
  task automatic send_item(input logic act, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.action     <= act;
    req_bus.byte_value <= b;
    do @(posedge clk); while (!req_bus.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(1'b0, s[i]);
  endtask

  task automatic send_frame(input logic [7:0] frame[$]);
    foreach (frame[i]) send_item(1'b0, frame[i]);
  endtask

  // Stops offering and waits until every predicted result has come out. The
  // first edge lets the checker count an item accepted at this very edge.
  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  // Write enable is dropped again before the task returns, so that it never
  // gets two assignments in the same step.
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Adds one byte at the end of a frame.
  function automatic void append_byte(ref logic [7:0] frame[$], input logic [7:0] b);
    frame.insert(frame.size(), b);
  endfunction

  // Appends a decimal number, now and then with a leading zero, which the
  // parser must accept.
  function automatic void add_number(ref logic [7:0] frame[$], input longint unsigned v);
    logic [7:0] digits[$];
    if ($urandom_range(0, 5) == 0) append_byte(frame, CH_ZERO);
    do begin
      digits.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) append_byte(frame, digits[i]);
  endfunction

  function automatic void add_crlf(ref logic [7:0] frame[$]);
    append_byte(frame, CH_CR);
    append_byte(frame, CH_LF);
  endfunction

  // Bytes biased toward the characters the grammar cares about.
  function automatic logic [7:0] grammar_byte();
    case ($urandom_range(0, 5))
      0: return CH_STAR;
      1: return CH_DOLLAR;
      2: return CH_CR;
      3: return CH_LF;
      4: return CH_ZERO + 8'($urandom_range(0, 9));
      default: return 8'($urandom);
    endcase
  endfunction

  // A well-formed request with random content within the current limits.
  // About one in five is damaged: a byte replaced, a byte inserted or the
  // tail cut off. A restart follows any damaged request, since the parser
  // may be holding an error or be stuck mid-request.
  task automatic send_request();
    logic [7:0]  frame[$];
    int unsigned n_params;
    int unsigned plen;
    int unsigned spot;
    bit          broken;
    broken   = ($urandom_range(0, 4) == 0);
    n_params = $urandom_range(0, (count_limit < 4) ? int'(count_limit) : 4);
    append_byte(frame, CH_STAR);
    add_number(frame, n_params);
    add_crlf(frame);
    repeat (n_params) begin
      plen = $urandom_range(0, (length_limit < 8) ? int'(length_limit) : 8);
      append_byte(frame, CH_DOLLAR);
      add_number(frame, plen);
      add_crlf(frame);
      repeat (plen) append_byte(frame, 8'($urandom));
      add_crlf(frame);
    end
    if (broken) begin
      spot = $urandom_range(0, frame.size() - 1);
      case ($urandom_range(0, 2))
        0: frame[spot] = grammar_byte();
        1: while (frame.size() > spot + 1) void'(frame.pop_back());
        default: frame.insert(spot, grammar_byte());
      endcase
    end
    send_frame(frame);
    if (broken) send_item(1'b1, 8'($urandom));
  endtask

  // Count and length at, or one past, their limits, sometimes far beyond any
  // 30-bit number. Only a few value bytes follow, then a restart.
  task automatic send_big_header();
    logic [7:0] frame[$];
    append_byte(frame, CH_STAR);
    if ($urandom_range(0, 3) == 0) add_number(frame, 64'd99999999999);
    else add_number(frame, count_limit + $urandom_range(0, 1));
    add_crlf(frame);
    append_byte(frame, CH_DOLLAR);
    if ($urandom_range(0, 3) == 0) add_number(frame, 64'd99999999999);
    else add_number(frame, length_limit + $urandom_range(0, 1));
    add_crlf(frame);
    repeat ($urandom_range(0, 3)) append_byte(frame, 8'($urandom));
    send_frame(frame);
    send_item(1'b1, 8'($urandom));
  endtask

  // Short runs of grammar-flavored junk, mostly rejected in the start phase.
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) send_item(1'b0, grammar_byte());
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic run_random_mix(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0: send_noise();
        1: send_big_header();
        default: send_request();
      endcase
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] wide;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_MAX_COUNT;
    cfg_data           <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.action     <= 1'b0;
    req_bus.byte_value <= 8'h00;
    idle_on      = 1'b1;
    holds_asked  = 0;
    items_sent   = 0;
    count_limit  = MAX_COUNT_RESET;
    length_limit = MAX_LENGTH_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset limits.
    // The start phase rejects anything but an asterisk, and the error then
    // holds even for an asterisk until a restart item arrives.
    send_item(1'b0, "x");
    send_item(1'b0, CH_STAR);
    send_item(1'b1, 8'hFF);
    // A count of zero finishes the request on the LF after the count.
    send_text("*0\r\n");
    // A zero length must be followed by CR straight away.
    send_text("*1\r\n$0\r\n\r\n");
    // A number with no digits before CR is an error.
    send_text("*\r");
    send_item(1'b1, 8'h00);

    // Random part with the reset limits. The long hold is requested as the
    // sender starts, so the block fills up and drops its input ready.
    holds_asked++;
    run_random_mix(ITEMS_PER_STEP);
    wait_for_drain();

    // Widest limits. Junk in the unused upper bits of the count write must be
    // ignored by the block.
    wide        = CFG_DATA_W'($urandom);
    wide[15:0]  = 16'hFFFF;
    write_reg(CFG_MAX_COUNT, wide);
    write_reg(CFG_MAX_LENGTH, CFG_DATA_W'(MAX_LENGTH_RESET));
    count_limit  = 65535;
    length_limit = MAX_LENGTH_RESET;
    run_random_mix(ITEMS_PER_STEP / 2);
    // The sender pauses here until every result is back, then resumes.
    wait_for_drain();
    run_random_mix(ITEMS_PER_STEP / 2);
    wait_for_drain();

    // Tightest limits: one parameter at most, and only empty values.
    write_reg(CFG_MAX_COUNT, CFG_DATA_W'(1));
    write_reg(CFG_MAX_LENGTH, '0);
    count_limit  = 1;
    length_limit = 0;
    run_random_mix(ITEMS_PER_STEP);
    wait_for_drain();

    // Random middle limits, with both sides running flat out to the end.
    count_limit  = $urandom_range(1, 12);
    length_limit = $urandom_range(1, 40);
    write_reg(CFG_MAX_COUNT, CFG_DATA_W'(count_limit));
    write_reg(CFG_MAX_LENGTH, CFG_DATA_W'(length_limit));
    idle_on = 1'b0;
    run_random_mix(ITEMS_PER_STEP);
    wait_for_drain();

    // Give any stray result item time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
